FILE: sv/lkvc_pkg.sv
// lkvc_pkg: shared types and constants for the lru key-value cache
// request and response payload structs, cell entry and control structs
// no dependencies
`default_nettype none

package lkvc_pkg;

    localparam int KEY_W   = 32;
    localparam int DATA_W  = 32;
    localparam int CAP_W   = 5;
    localparam int PDATA_W = 32;
    localparam int PADDR_W = 3;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
    localparam logic [PADDR_W-3:0] REG_CAPACITY = '0;

    typedef enum logic [0:0] {
        REQ_GET = 1'b0,
        REQ_PUT = 1'b1
    } req_type_t;

    typedef struct packed {
        req_type_t                req_type;
        logic signed [KEY_W-1:0]  key;
        logic signed [DATA_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic                     hit;
        logic signed [DATA_W-1:0] read_value;
    } rsp_t;

    typedef struct packed {
        logic              valid;
        logic [KEY_W-1:0]  key;
        logic [DATA_W-1:0] data;
    } entry_t;

    typedef struct packed {
        logic load;
        logic kill;
    } cell_ctrl_t;

endpackage

`default_nettype wire

FILE: sv/lru_key_value_cache_top.sv
// lru_key_value_cache_top: fully associative key-value cache with lru replacement
// a chain of lkvc_cell slots kept in recency order, request register, response register
// depends on lkvc_pkg and lkvc_cell
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+------------------------------
//  req      | req_valid / req_ready      | req_t: req_type, key, value
//  rsp      | rsp_valid / rsp_ready      | rsp_t: hit, read_value
//  config   | psel penable pwrite pready | paddr, pwdata, prdata
//
// a request is registered at acceptance and resolved once it fires: all slots
// compare in parallel and the chain shifts once, so one request per cycle is taken
// while the response register is free or drains; a get waits on a full response register
// reset clears every valid bit and the occupancy count at once; no clearing pass
// a put gives no response and never waits on rsp_ready
`default_nettype none

module lru_key_value_cache_top
    import lkvc_pkg::*;
#(
    parameter int ENTRIES = 16
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    output logic                    req_ready,
    input  wire req_t               req,
    output logic                    rsp_valid,
    input  wire logic               rsp_ready,
    output rsp_t                    rsp,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0]      prdata,
    output logic                    pready
);

    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    logic [CAP_W-1:0] capacity_reg;
    logic [CAP_W-1:0] capacity_next;
    logic [CNT_W-1:0] occ_reg;
    logic [CNT_W-1:0] occ_next;
    logic             busy_reg;
    logic             busy_next;
    req_t             req_reg;
    req_t             req_next;
    logic             rsp_valid_reg;
    logic             rsp_valid_next;
    rsp_t             rsp_reg;
    rsp_t             rsp_next;

    logic                 req_accept;
    logic                 fire;
    logic                 cfg_write;
    logic [PADDR_W-3:0]   reg_index;
    logic [ENTRIES-1:0]   match;
    entry_t               entries [ENTRIES];
    cell_ctrl_t           ctrl [ENTRIES];
    entry_t               hit_entry;
    entry_t               front;
    logic                 hit;
    logic                 is_put;
    logic                 put_miss;
    logic                 evict;
    logic [CMP_W-1:0]     cap_eff;

    assign pready    = 1'b1;
    assign reg_index = paddr[PADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (reg_index == REG_CAPACITY) ? PDATA_W'(capacity_reg) : '0;

    always_comb
    begin
        capacity_next = capacity_reg;
        if (cfg_write && (reg_index == REG_CAPACITY))
        begin
            capacity_next = pwdata[CAP_W-1:0];
        end
    end

    always_comb
    begin
        cap_eff = CMP_W'(capacity_reg);
        if (capacity_reg == '0)
        begin
            cap_eff = CMP_W'(1);
        end
        else if (CMP_W'(capacity_reg) > CMP_W'(ENTRIES))
        begin
            cap_eff = CMP_W'(ENTRIES);
        end
    end

    assign is_put     = (req_reg.req_type == REQ_PUT);
    assign fire       = busy_reg && (is_put || !rsp_valid_reg || rsp_ready);
    assign req_ready  = !busy_reg || fire;
    assign req_accept = req_valid && req_ready;

    // one-hot select of the matching slot
    always_comb
    begin
        hit_entry = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (match[i])
            begin
                hit_entry = hit_entry | entries[i];
            end
        end
    end

    assign hit      = |match;
    assign put_miss = fire && is_put && !hit;
    assign evict    = CMP_W'(occ_reg) >= cap_eff;

    always_comb
    begin
        front.valid = 1'b1;
        front.key   = req_reg.key;
        front.data  = is_put ? req_reg.value : hit_entry.data;
    end

    genvar gi;
    generate
        for (gi = 0; gi < ENTRIES; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_head
                assign ctrl[gi].load = put_miss || (fire && hit);
                assign ctrl[gi].kill = 1'b0;
                lkvc_cell u_cell (
                    .clk        (clk),
                    .rst_n      (rst_n),
                    .ctrl       (ctrl[gi]),
                    .shift_in   (front),
                    .lookup_key (req_reg.key),
                    .entry      (entries[gi]),
                    .match      (match[gi])
                );
            end
            else
            begin : g_body
                // hit slot and every more recent slot move down by one
                assign ctrl[gi].load = put_miss || (fire && (|match[ENTRIES-1:gi]));
                // the tail slot falls off on eviction
                assign ctrl[gi].kill = evict && entries[gi-1].valid && !entries[gi].valid;
                lkvc_cell u_cell (
                    .clk        (clk),
                    .rst_n      (rst_n),
                    .ctrl       (ctrl[gi]),
                    .shift_in   (entries[gi-1]),
                    .lookup_key (req_reg.key),
                    .entry      (entries[gi]),
                    .match      (match[gi])
                );
            end
        end
    endgenerate

    always_comb
    begin
        occ_next = occ_reg;
        if (put_miss && !evict)
        begin
            occ_next = occ_reg + CNT_W'(1);
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        req_next  = req_reg;
        if (req_accept)
        begin
            busy_next = 1'b1;
            req_next  = req;
        end
        else if (fire)
        begin
            busy_next = 1'b0;
        end
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        if (fire && !is_put)
        begin
            rsp_valid_next      = 1'b1;
            rsp_next.hit        = hit;
            rsp_next.read_value = hit ? hit_entry.data : '1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg  <= CAP_RESET;
            occ_reg       <= '0;
            busy_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            capacity_reg  <= capacity_next;
            occ_reg       <= occ_next;
            busy_reg      <= busy_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

FILE: sv/lkvc_cell.sv
// lkvc_cell: one slot of the recency-ordered chain
// holds key, data and valid; compares against the lookup key; loads from its neighbor
// depends on lkvc_pkg
`default_nettype none

module lkvc_cell
    import lkvc_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire cell_ctrl_t       ctrl,
    input  wire entry_t           shift_in,
    input  wire logic [KEY_W-1:0] lookup_key,
    output entry_t                entry,
    output logic                  match
);

    logic              valid_reg;
    logic              valid_next;
    logic [KEY_W-1:0]  key_reg;
    logic [KEY_W-1:0]  key_next;
    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;

    always_comb
    begin
        valid_next = valid_reg;
        key_next   = key_reg;
        data_next  = data_reg;
        if (ctrl.load)
        begin
            valid_next = shift_in.valid & ~ctrl.kill;
            key_next   = shift_in.key;
            data_next  = shift_in.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg  <= key_next;
        data_reg <= data_next;
    end

    assign match = valid_reg && (key_reg == lookup_key);

    assign entry.valid = valid_reg;
    assign entry.key   = key_reg;
    assign entry.data  = data_reg;

endmodule

`default_nettype wire

FILE: sv/lkvc_checker.sv
// lkvc_checker: port-level assertions for lru_key_value_cache_top
// bound to the top level below
// depends on lkvc_pkg
`default_nettype none

module lkvc_checker
    import lkvc_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               rsp_valid,
    input wire logic               rsp_ready,
    input wire rsp_t               rsp,
    input wire logic               psel,
    input wire logic               pwrite,
    input wire logic [PDATA_W-1:0] prdata
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("response changed while stalled");

    a_miss_value: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.hit |-> rsp.read_value == '1)
        else $error("miss response not all ones");

    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> rsp_valid !== 1'b1)
        else $error("response valid during reset");

    a_prdata_width: assert property (@(posedge clk) disable iff (!rst_n)
        psel && !pwrite |-> prdata[PDATA_W-1:CAP_W] == '0)
        else $error("capacity readback wider than register");

endmodule

bind lru_key_value_cache_top lkvc_checker u_lkvc_checker (.*);

`default_nettype wire
